[hdl/spg_pkg.sv]
// Shared constants, exponent table and types of the sigmoid probability block.
`default_nettype none

package spg_pkg;

  localparam int ExpTableBits = 6;
  localparam int FracBits     = 20;
  localparam int TabBits      = ExpTableBits + 1;
  localparam int TabSize      = (1 << ExpTableBits) + 1;
  localparam int InterpBits   = FracBits - ExpTableBits;

  localparam logic [16:0] Log2eQ15 = 17'd47274;
  localparam logic signed [32:0] ZMin = -33'sd16777216;
  localparam logic signed [32:0] ZMax = 33'sd16777215;

  localparam int DenBits = 55;
  localparam int QuoBits = 17;
  localparam int RemBits = DenBits + QuoBits;

  localparam int NumDivCells = QuoBits;
  localparam int DivFirst    = 5;
  localparam int StProd      = DivFirst + NumDivCells;
  localparam int StGrad      = StProd + 1;
  localparam int StOut       = StGrad + 1;
  localparam int NumStages   = StOut + 1;

  localparam int CfgIdxBits = 8;
  localparam logic [CfgIdxBits-1:0] RegSlopeA  = 8'd0;
  localparam logic [CfgIdxBits-1:0] RegOffsetB = 8'd1;

  typedef logic [31:0] exp_tab_t [TabSize];

  typedef struct packed {
    logic [RemBits-1:0] rem;
    logic [DenBits-1:0] den;
    logic [QuoBits-1:0] quo;
    logic signed [15:0] score;
  } div_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] val;
    logic [63:0] res;
    logic [63:0] bt;
    val = v;
    res = 64'd0;
    bt  = 64'd1 << 62;
    while (bt > val) bt = bt >> 2;
    while (bt != 64'd0) begin
      if (val >= res + bt) begin
        val = val - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Entry k holds 2^(k/2^ExpTableBits) in Q2.30, built from repeated square roots of two.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] roots [ExpTableBits+1];
    logic [63:0] acc;
    roots[0] = 64'd1 << 31;
    for (int j = 1; j <= ExpTableBits; j++) roots[j] = isqrt64(roots[j-1] << 30);
    for (int k = 0; k < (1 << ExpTableBits); k++) begin
      acc = 64'd1 << 30;
      for (int i = ExpTableBits - 1; i >= 0; i--) begin
        if (((k >> i) & 1) == 1) acc = (acc * roots[ExpTableBits-i]) >> 30;
      end
      tab[k] = acc[31:0];
    end
    tab[TabSize-1] = 32'h8000_0000;
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

`default_nettype wire

[hdl/spg_if.sv]
// Request channel interfaces of the sigmoid probability block.
`default_nettype none

interface spg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spg_pkg::CfgIdxBits-1:0]  index;
  logic [15:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface spg_score_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score;
  modport source (output valid, score, input ready);
  modport sink (input valid, score, output ready);
endinterface

interface spg_result_if;
  logic               valid;
  logic               ready;
  logic [15:0]        probability;
  logic signed [14:0] grad_offset;
  logic signed [31:0] grad_slope;
  modport source (output valid, probability, grad_offset, grad_slope, input ready);
  modport sink (input valid, probability, grad_offset, grad_slope, output ready);
endinterface

`default_nettype wire

[hdl/spg_div_cell.sv]
// One restoring division cell: decides one quotient bit and passes the remainder on.
`default_nettype none

module spg_div_cell (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  spg_pkg::div_t      req_i,
  output spg_pkg::div_t      req_o
);

  logic [spg_pkg::RemBits-1:0] dsh;
  logic [spg_pkg::RemBits-1:0] rem_sub;
  logic                        ge;
  spg_pkg::div_t               cell_d;
  spg_pkg::div_t               cell_q;

  // The divisor is compared at the weight of the top quotient bit; the remainder
  // moves up one place per cell instead.
  always_comb begin
    dsh          = {1'b0, req_i.den, {(spg_pkg::QuoBits-1){1'b0}}};
    ge           = (req_i.rem >= dsh);
    rem_sub      = ge ? (req_i.rem - dsh) : req_i.rem;
    cell_d       = req_i;
    cell_d.rem   = {rem_sub[spg_pkg::RemBits-2:0], 1'b0};
    cell_d.quo   = {req_i.quo[spg_pkg::QuoBits-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign req_o = cell_q;

endmodule

`default_nettype wire

[hdl/sigmoid_probability_with_gradient.sv]
// Top level of the sigmoid probability and gradient pipeline.
// Platt sigmoid scaling: each score x (Q4.12) gives f = 1/(1+exp(A*x+B)) in unsigned
// Q0.16 saturated at 65535, the offset gradient -f(1-f) and the slope gradient
// -f(1-f)*x, with A and B written through the configuration channel (Q8.8). The
// block takes one request per clock while out_o.ready does not stall the pipeline;
// the exponent stages come first, then seventeen division cells, one per quotient
// bit, then the gradient stages. Every stage holds its own valid bit, so bubbles
// close up; a new request can be taken while a result waits in the output register
// if an earlier stage is empty. The exponent is clamped to [-16,16) and evaluated
// as a power of two from a 65-entry table with linear interpolation.
`default_nettype none

module sigmoid_probability_with_gradient (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spg_cfg_if.sink    cfg_i,
  spg_score_if.sink  in_i,
  spg_result_if.source out_o
);

  localparam int NS = spg_pkg::NumStages;

  logic [15:0] slope_a_q;
  logic [15:0] offset_b_q;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_d;
  logic [NS:0]   en;

  // Stage payloads.
  logic signed [24:0] z_q;
  logic signed [15:0] x0_q;
  logic signed [6:0]  n1_q;
  logic [spg_pkg::FracBits-1:0] r1_q;
  logic signed [15:0] x1_q;
  logic [31:0]        lo2_q;
  logic [31:0]        diff2_q;
  logic [spg_pkg::InterpBits-1:0] w2_q;
  logic signed [6:0]  n2_q;
  logic signed [15:0] x2_q;
  logic [31:0]        m3_q;
  logic signed [6:0]  n3_q;
  logic signed [15:0] x3_q;
  spg_pkg::div_t      div4_q;
  logic [33:0]        p_q;
  logic [16:0]        f_q;
  logic signed [15:0] xp_q;
  logic signed [14:0] d_q;
  logic [15:0]        prob_q;
  logic signed [15:0] xg_q;
  logic [15:0]        prob_out_q;
  logic signed [14:0] goff_out_q;
  logic signed [31:0] gslope_out_q;

  spg_pkg::div_t div_out [spg_pkg::NumDivCells];

  // Combinational values of each stage.
  logic signed [31:0] ax;
  logic signed [32:0] zsum;
  logic signed [24:0] z_d;
  logic signed [42:0] tprod;
  logic signed [27:0] t;
  logic [spg_pkg::ExpTableBits-1:0] k;
  logic [spg_pkg::TabBits-1:0] kx;
  logic [spg_pkg::TabBits-1:0] kx1;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [31+spg_pkg::InterpBits:0] interp;
  logic [31:0] m_d;
  logic [6:0]  nneg;
  logic [spg_pkg::DenBits-1:0] e_val;
  logic [spg_pkg::DenBits-1:0] den;
  logic [spg_pkg::DenBits-1:0] num;
  spg_pkg::div_t div_d;
  logic [16:0] f_d;
  logic [16:0] f_comp;
  logic [33:0] p_d;
  logic [33:0] mag;
  logic signed [14:0] d_d;
  logic signed [30:0] gs;

  // Configuration writes; an unknown index is dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_a_q  <= 16'hFF00;
      offset_b_q <= 16'h0000;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        spg_pkg::RegSlopeA:  slope_a_q  <= cfg_i.data;
        spg_pkg::RegOffsetB: offset_b_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[NS] = out_o.ready;
    for (int s = NS - 1; s >= 0; s--) en[s] = !v_q[s] || en[s+1];
    v_d = v_q;
    if (en[0]) v_d[0] = in_i.valid;
    for (int s = 1; s < NS; s++) begin
      if (en[s]) v_d[s] = v_q[s-1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Exponent z = A*x + B in Q.20, clamped.
  always_comb begin
    ax   = $signed(slope_a_q) * in_i.score;
    zsum = 33'(ax) + 33'($signed({offset_b_q, 12'h000}));
    if (zsum < spg_pkg::ZMin) begin
      z_d = 25'(spg_pkg::ZMin);
    end else if (zsum > spg_pkg::ZMax) begin
      z_d = 25'(spg_pkg::ZMax);
    end else begin
      z_d = zsum[24:0];
    end
  end

  // Scale by log2(e); the integer part is the shift, the fraction indexes the table.
  always_comb begin
    tprod = z_q * $signed({1'b0, spg_pkg::Log2eQ15});
    t     = tprod[42:15];
  end

  always_comb begin
    k   = r1_q[spg_pkg::FracBits-1 -: spg_pkg::ExpTableBits];
    kx  = {1'b0, k};
    kx1 = kx + 1'b1;
    lo  = spg_pkg::ExpTab[kx];
    hi  = spg_pkg::ExpTab[kx1];
  end

  always_comb begin
    interp = diff2_q * w2_q;
    m_d    = lo2_q + 32'(interp >> spg_pkg::InterpBits);
  end

  // Apply the power of two and set up the division of 2^46 (rounded) by 2^30 + E.
  always_comb begin
    nneg = 7'(-n3_q);
    if (!n3_q[6]) begin
      e_val = {23'h0, m3_q} << n3_q[4:0];
    end else begin
      e_val = {23'h0, m3_q} >> nneg[4:0];
    end
    den          = (spg_pkg::DenBits'(1) << 30) + e_val;
    num          = (spg_pkg::DenBits'(1) << 46) + (den >> 1);
    div_d.rem    = {{spg_pkg::QuoBits{1'b0}}, num};
    div_d.den    = den;
    div_d.quo    = '0;
    div_d.score  = x3_q;
  end

  for (genvar c = 0; c < spg_pkg::NumDivCells; c++) begin : g_div
    if (c == 0) begin : g_first
      spg_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en[spg_pkg::DivFirst]),
        .req_i (div4_q),
        .req_o (div_out[c])
      );
    end else begin : g_next
      spg_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en[spg_pkg::DivFirst+c]),
        .req_i (div_out[c-1]),
        .req_o (div_out[c])
      );
    end
  end

  // Gradients from the quotient.
  always_comb begin
    f_d    = div_out[spg_pkg::NumDivCells-1].quo;
    f_comp = 17'h10000 - f_d;
    p_d    = 34'(f_d) * 34'(f_comp);
    mag    = (p_q + 34'd32768) >> 16;
    d_d    = 15'(0) - mag[14:0];
    gs     = d_q * xg_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      z_q  <= z_d;
      x0_q <= in_i.score;
    end
    if (en[1]) begin
      n1_q <= t[26:20];
      r1_q <= t[19:0];
      x1_q <= x0_q;
    end
    if (en[2]) begin
      lo2_q   <= lo;
      diff2_q <= hi - lo;
      w2_q    <= r1_q[spg_pkg::InterpBits-1:0];
      n2_q    <= n1_q;
      x2_q    <= x1_q;
    end
    if (en[3]) begin
      m3_q <= m_d;
      n3_q <= n2_q;
      x3_q <= x2_q;
    end
    if (en[4]) begin
      div4_q <= div_d;
    end
    if (en[spg_pkg::StProd]) begin
      p_q  <= p_d;
      f_q  <= f_d;
      xp_q <= div_out[spg_pkg::NumDivCells-1].score;
    end
    if (en[spg_pkg::StGrad]) begin
      d_q    <= d_d;
      prob_q <= f_q[16] ? 16'hFFFF : f_q[15:0];
      xg_q   <= xp_q;
    end
    if (en[spg_pkg::StOut]) begin
      prob_out_q   <= prob_q;
      goff_out_q   <= d_q;
      gslope_out_q <= 32'(gs);
    end
  end

  assign out_o.valid       = v_q[spg_pkg::StOut];
  assign out_o.probability = prob_out_q;
  assign out_o.grad_offset = goff_out_q;
  assign out_o.grad_slope  = gslope_out_q;

  // The quotient never exceeds one in Q0.16.
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[spg_pkg::StProd] |-> (f_q <= 17'h10000))
    else $error("quotient above one");

  // The offset gradient is never positive.
  a_goff_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.grad_offset[14] || out_o.grad_offset == 15'sd0))
    else $error("positive offset gradient");

  // A stalled result in the last division cell stays there.
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[spg_pkg::StProd-1] && !en[spg_pkg::StProd-1]) |=> v_q[spg_pkg::StProd-1])
    else $error("division result lost");

endmodule

`default_nettype wire

[verif/tb_sigmoid_scoreboard.sv]
// Scoreboard class that predicts and checks the sigmoid probability results.
`timescale 1ns / 100ps

class sigmoid_scoreboard;
  typedef struct {
    logic [15:0]        probability;
    logic signed [14:0] grad_offset;
    logic signed [31:0] grad_slope;
  } sig_result_t;

  logic signed [15:0] slope_a;
  logic signed [15:0] offset_b;
  logic [31:0]        exp_rom [spg_pkg::TabSize];
  sig_result_t        pending_q[$];
  int                 mismatches;

  function new();
    logic [63:0] roots [spg_pkg::ExpTableBits+1];
    logic [63:0] acc;
    roots[0] = 64'd1 << 31;
    for (int j = 1; j <= spg_pkg::ExpTableBits; j++) roots[j] = int_sqrt(roots[j-1] << 30);
    for (int k = 0; k < (1 << spg_pkg::ExpTableBits); k++) begin
      acc = 64'd1 << 30;
      for (int i = spg_pkg::ExpTableBits - 1; i >= 0; i--)
        if ((k >> i) & 1) acc = (acc * roots[spg_pkg::ExpTableBits-i]) >> 30;
      exp_rom[k] = acc[31:0];
    end
    exp_rom[spg_pkg::TabSize-1] = 32'h8000_0000;
    slope_a    = -16'sd256;
    offset_b   = 16'sd0;
    mismatches = 0;
  endfunction

  static function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem = v;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function void write_reg(logic [spg_pkg::CfgIdxBits-1:0] idx, logic [15:0] val);
    if (idx == spg_pkg::RegSlopeA) slope_a = val;
    else if (idx == spg_pkg::RegOffsetB) offset_b = val;
  endfunction

  function void note_score(logic signed [15:0] x);
    longint      z, t, n, d;
    logic [63:0] u, r, k, w, m, e, den, f, p;
    sig_result_t res;
    z = longint'(slope_a) * longint'(x) + longint'(offset_b) * 4096;
    if (z < -64'sd16777216) z = -64'sd16777216;
    if (z > 64'sd16777215) z = 64'sd16777215;
    t = (z * 47274) >>> 15;
    u = t + (64'sd32 << 20);
    n = longint'(u >> 20) - 32;
    r = u & 64'hF_FFFF;
    k = r >> spg_pkg::InterpBits;
    w = r & ((64'd1 << spg_pkg::InterpBits) - 1);
    m = exp_rom[k] + (((exp_rom[k+1] - exp_rom[k]) * w) >> spg_pkg::InterpBits);
    e = (n >= 0) ? (m << n) : (m >> (-n));
    den = (64'd1 << 30) + e;
    f = ((64'd1 << 46) + (den >> 1)) / den;
    if (f > 65536) f = 65536;
    p = f * (65536 - f);
    d = -longint'((p + 32768) >> 16);
    res.probability = (f > 65535) ? 16'hFFFF : f[15:0];
    res.grad_offset = d[14:0];
    res.grad_slope  = 32'(d * longint'(x));
    pending_q.push_back(res);
  endfunction

  function void check_result(logic [15:0] prob, logic signed [14:0] g_off,
                             logic signed [31:0] g_slope);
    sig_result_t want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result prob=%0d", prob);
      return;
    end
    want = pending_q.pop_front();
    if (want.probability !== prob || want.grad_offset !== g_off
        || want.grad_slope !== g_slope) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                 want.probability, want.grad_offset, want.grad_slope,
                 prob, g_off, g_slope);
    end
  endfunction
endclass

[verif/tb_top.sv]
// Top-level testbench driving scores and registers into the sigmoid block.
`timescale 1ns / 100ps

module tb_top;

  logic clk_i;
  logic rst_ni;
  // When set, both sides run without idling for a stretch of requests.
  bit   no_idle;

  spg_cfg_if    cfg_if ();
  spg_score_if  score_if ();
  spg_result_if result_if ();

  sigmoid_probability_with_gradient DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink),
    .in_i  (score_if.sink),
    .out_o (result_if.source)
  );

  sigmoid_scoreboard probability_board;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Writes one register while the pipeline is empty.
  task automatic write_register(logic [spg_pkg::CfgIdxBits-1:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    probability_board.write_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one score request, with a random idle gap beforehand unless no_idle is set.
  task automatic send_score(logic signed [15:0] x);
    while (!no_idle && $urandom_range(99) < 19) begin
      score_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    score_if.valid <= 1'b1;
    score_if.score <= x;
    do @(posedge clk_i); while (!score_if.ready);
    probability_board.note_score(x);
  endtask

  // Waits until every expected result is out, then for the pipeline to drain.
  task automatic drain();
    score_if.valid <= 1'b0;
    while (probability_board.pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // A random score, biased so that the exponent often lands inside the live range.
  function automatic logic signed [15:0] pick_score();
    case ($urandom_range(3))
      0: pick_score = $signed(16'($urandom_range(65535)));
      1: pick_score = $signed(16'($urandom_range(1023))) - 16'sd512;
      default: pick_score = $signed(16'($urandom_range(16383))) - 16'sd8192;
    endcase
  endfunction

  // Results are taken on the edge; the ready seen there is the one driven before.
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      probability_board.check_result(result_if.probability, result_if.grad_offset,
                                     result_if.grad_slope);
    result_if.ready <= no_idle || ($urandom_range(99) >= 19);
  end

  initial begin
    logic signed [15:0] slopes [6];
    logic signed [15:0] offsets [6];
    logic signed [15:0] edge_scores [12];
    probability_board = new();
    slopes  = '{-16'sd256, 16'sh7FFF, -16'sh8000, 16'sd256, 16'sd16, 16'sd0};
    offsets = '{16'sd0, 16'sh7FFF, -16'sh8000, 16'sd0, -16'sd300, 16'sd512};
    edge_scores = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh0001, -16'sd1, 16'sh1000,
                    -16'sh1000, 16'sh4000, -16'sh4000, 16'sh5555, 16'shAAAA, 16'sh0800};
    no_idle         = 1'b0;
    rst_ni          = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    score_if.valid  = 1'b0;
    score_if.score  = '0;
    result_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings, then two unknown register indices and saturating
    // settings where the probability of one appears and the exponent clamps.
    foreach (edge_scores[i]) send_score(edge_scores[i]);
    drain();
    write_register(8'd2, 16'h1234);
    write_register(8'hFF, 16'hFFFF);
    write_register(spg_pkg::RegSlopeA, 16'h8000);
    write_register(spg_pkg::RegOffsetB, 16'h8000);
    foreach (edge_scores[i]) send_score(edge_scores[i]);
    drain();

    // Random part over several register settings, extremes among them.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 6) begin
        write_register(spg_pkg::RegSlopeA, slopes[phase]);
        write_register(spg_pkg::RegOffsetB, offsets[phase]);
      end else begin
        write_register(spg_pkg::RegSlopeA, 16'($urandom_range(65535)));
        write_register(spg_pkg::RegOffsetB, 16'($urandom_range(1023)) - 16'd512);
      end
      no_idle = (phase == 3);
      for (int i = 0; i < 160; i++) send_score(pick_score());
      no_idle = 1'b0;
      drain();
    end

    if (probability_board.mismatches == 0 && probability_board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end
endmodule
